>>> hdl/nwrs_pkg.sv
`default_nettype none

package nwrs_pkg;

    // List geometry and index masking
    localparam int LIST_DEPTH = 16;
    localparam int INDEX_BITS = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam logic [15:0] IDX_MASK = (INDEX_BITS >= 16) ? 16'hFFFF
                                     : 16'((17'd1 << INDEX_BITS) - 17'd1);

    // Register map: byte address 4*index, index taken from paddr[2]
    localparam logic REG_RADIUS    = 1'b0;
    localparam logic REG_MAX_CONNS = 1'b1;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;

    typedef struct packed {
        logic [15:0] dest;
        logic [31:0] distance;
        logic [1:0]  link_type;
    } entry_t;

    // Hand-over of a finished list from the insertion stage to the drain
    typedef struct packed {
        logic             load;
        logic [15:0]      src;
        logic [CNT_W-1:0] count;
    } flush_t;

endpackage

`default_nettype wire

>>> hdl/nwrs_cfg.sv
`default_nettype none

module nwrs_cfg
    import nwrs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [31:0]      radius_threshold,
    output logic [4:0]       max_conns
);

    logic [31:0] radius_threshold_reg;
    logic [4:0]  max_conns_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_threshold_reg <= '0;
            max_conns_reg        <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_RADIUS:    radius_threshold_reg <= pwdata;
                REG_MAX_CONNS: max_conns_reg        <= pwdata[4:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_RADIUS:    prdata = radius_threshold_reg;
            REG_MAX_CONNS: prdata = {27'd0, max_conns_reg};
            default:       prdata = '0;
        endcase
    end

    assign radius_threshold = radius_threshold_reg;
    assign max_conns        = max_conns_reg;

endmodule

`default_nettype wire

>>> hdl/nwrs_insert.sv
`default_nettype none

module nwrs_insert
    import nwrs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [15:0]            in_src,
    input  wire logic [15:0]            in_dest,
    input  wire logic [31:0]            in_dist,
    input  wire logic [1:0]             in_type,
    input  wire logic                   in_last,
    output logic                        in_ready,
    input  wire logic [31:0]            radius_threshold,
    input  wire logic [4:0]             max_conns,
    input  wire logic                   drain_idle,
    output flush_t                      flush,
    output entry_t                      flush_list [LIST_DEPTH]
);

    logic             in_valid_reg;
    logic [15:0]      in_src_reg;
    logic [15:0]      in_dest_reg;
    logic [31:0]      in_dist_reg;
    logic [1:0]       in_type_reg;
    logic             in_last_reg;

    entry_t           list_reg  [LIST_DEPTH];
    entry_t           list_next [LIST_DEPTH];
    logic [CNT_W-1:0] kept_count_reg;
    logic [CNT_W-1:0] kept_count_next;

    logic             adv;
    logic [7:0]       mc_wide;
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] count_next;
    logic [LIST_DEPTH-1:0] le;
    logic [LIST_DEPTH-1:0] cap_mask;
    logic [15:0]      src_m;
    logic [15:0]      dest_m;
    logic             link_ok;
    logic             take;
    entry_t           new_entry;

    // Advance the held item unless it closes a list and the drain is busy
    assign adv      = in_valid_reg && (!in_last_reg || drain_idle);
    assign in_ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_src_reg  <= in_src;
            in_dest_reg <= in_dest;
            in_dist_reg <= in_dist;
            in_type_reg <= in_type;
            in_last_reg <= in_last;
        end
    end

    assign mc_wide = 8'(max_conns);
    assign cap     = (mc_wide > 8'(LIST_DEPTH)) ? CNT_W'(LIST_DEPTH) : CNT_W'(mc_wide);
    assign cnt_eff = (kept_count_reg > cap) ? cap : kept_count_reg;

    assign src_m   = in_src_reg & IDX_MASK;
    assign dest_m  = in_dest_reg & IDX_MASK;
    assign link_ok = (src_m != dest_m) && (in_dist_reg <= radius_threshold);

    assign new_entry.dest      = dest_m;
    assign new_entry.distance  = in_dist_reg;
    assign new_entry.link_type = in_type_reg;

    // le is a thermometer: kept entries that rank ahead of the newcomer
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            le[i]       = (CNT_W'(i) < cnt_eff) && (list_reg[i].distance <= in_dist_reg);
            cap_mask[i] = (CNT_W'(i) < cap);
        end
    end

    assign take       = link_ok && (|(~le & cap_mask));
    assign count_next = (take && (cnt_eff < cap)) ? cnt_eff + 1'b1 : cnt_eff;

    always_comb
    begin
        if (!take || le[0])
            list_next[0] = list_reg[0];
        else
            list_next[0] = new_entry;
        for (int i = 1; i < LIST_DEPTH; i++)
        begin
            if (!take || le[i])
                list_next[i] = list_reg[i];
            else if (le[i-1])
                list_next[i] = new_entry;
            else
                list_next[i] = list_reg[i-1];
        end
    end

    assign kept_count_next = in_last_reg ? '0 : count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_count_reg <= '0;
        end
        else if (adv)
        begin
            kept_count_reg <= kept_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            list_reg <= list_next;
        end
    end

    assign flush.load  = adv && in_last_reg;
    assign flush.src   = src_m;
    assign flush.count = count_next;
    assign flush_list  = list_next;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_count_reg <= CNT_W'(LIST_DEPTH))
        else $error("kept count beyond list depth");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_last_reg) |=> (kept_count_reg == '0))
        else $error("list not cleared after closing item");

    a_count_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        flush.load |-> (flush.count <= cap))
        else $error("flushed count exceeds limit");

endmodule

`default_nettype wire

>>> hdl/nwrs_drain.sv
`default_nettype none

module nwrs_drain
    import nwrs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire flush_t      flush,
    input  wire entry_t      flush_list [LIST_DEPTH],
    output logic             drain_idle,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      out_source,
    output logic [15:0]      out_dest,
    output logic [1:0]       out_type,
    output logic [31:0]      out_distance,
    output logic             empty_flag,
    output logic             last_result
);

    entry_t           drain_list_reg [LIST_DEPTH];
    logic [CNT_W-1:0] drain_left_reg;
    logic             drain_empty_reg;
    logic [15:0]      drain_src_reg;

    logic             out_valid_reg;
    logic [15:0]      out_source_reg;
    logic [15:0]      out_dest_reg;
    logic [1:0]       out_type_reg;
    logic [31:0]      out_distance_reg;
    logic             empty_flag_reg;
    logic             last_result_reg;

    logic             load_out;

    assign drain_idle = (drain_left_reg == '0);
    assign load_out   = !drain_idle && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_left_reg  <= '0;
            drain_empty_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (flush.load)
            begin
                drain_left_reg  <= (flush.count == '0) ? CNT_W'(1) : flush.count;
                drain_empty_reg <= (flush.count == '0);
            end
            else if (load_out)
            begin
                drain_left_reg <= drain_left_reg - 1'b1;
            end

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flush.load)
        begin
            drain_list_reg <= flush_list;
            drain_src_reg  <= flush.src;
        end
        else if (load_out)
        begin
            for (int i = 0; i < LIST_DEPTH - 1; i++)
                drain_list_reg[i] <= drain_list_reg[i+1];
        end

        if (load_out)
        begin
            if (drain_empty_reg)
            begin
                out_source_reg   <= '0;
                out_dest_reg     <= '0;
                out_type_reg     <= '0;
                out_distance_reg <= '0;
            end
            else
            begin
                out_source_reg   <= drain_src_reg;
                out_dest_reg     <= drain_list_reg[0].dest;
                out_type_reg     <= drain_list_reg[0].link_type;
                out_distance_reg <= drain_list_reg[0].distance;
            end
            empty_flag_reg  <= drain_empty_reg;
            last_result_reg <= (drain_left_reg == CNT_W'(1));
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_source   = out_source_reg;
    assign out_dest     = out_dest_reg;
    assign out_type     = out_type_reg;
    assign out_distance = out_distance_reg;
    assign empty_flag   = empty_flag_reg;
    assign last_result  = last_result_reg;

    a_flush_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        flush.load |-> drain_idle)
        else $error("list handed over while drain busy");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && empty_flag_reg) |-> last_result_reg)
        else $error("empty result not marked last");

endmodule

`default_nettype wire

>>> hdl/nearest_within_radius_selector.sv
`default_nettype none

// Channel    | Dir | Handshake                 | Payload
// -----------+-----+---------------------------+------------------------------------------
// s_axis     | in  | s_tvalid / s_tready       | s_tdata: source_index, dest_index,
//            |     |                           |   distance, link_type; s_tlast: last_candidate
// m_axis     | out | m_tvalid / m_tready       | m_tdata: out_source, out_dest, out_type,
//            |     |                           |   out_distance; m_tuser: empty_flag;
//            |     |                           |   m_tlast: last_result
// apb        | in  | psel, penable, pready     | 0x0 radius_threshold, 0x4 max_conns
//
// Flow: one candidate per cycle, unless a closing candidate waits, through an input register
//   and a parallel compare-and-shift insertion into the sorted list; results of a closed list
//   pass through the drain buffer into the output register.
// A closing candidate waits in the input register until the drain buffer has
//   handed out every result of the previous source.
// Reset clears handshake state, kept count and configuration registers; list contents are not reset.
// Stalls on m_tready hold the output register and back up through the drain buffer.

module nearest_within_radius_selector
    import nwrs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [15:0] source_index, [31:16] dest_index, [63:32] distance,
    // [65:64] link_type, [71:66] zero
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tlast,

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [15:0] out_source, [31:16] out_dest, [33:32] out_type,
    // [65:34] out_distance, [71:66] zero
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // [0] empty_flag
    output logic                        m_tuser,
    output logic                        m_tlast,

    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [31:0] radius_threshold;
    logic [4:0]  max_conns;
    logic        drain_idle;
    flush_t      flush;
    entry_t      flush_list [LIST_DEPTH];

    logic [15:0] out_source;
    logic [15:0] out_dest;
    logic [1:0]  out_type;
    logic [31:0] out_distance;

    // Hold configuration; the user must write it only while no item is in flight (not enforced here)
    nwrs_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .radius_threshold (radius_threshold),
        .max_conns        (max_conns)
    );

    // Register the candidate, filter it, and insert it into the sorted list
    nwrs_insert u_insert (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (s_tvalid),
        .in_src           (s_tdata[15:0]),
        .in_dest          (s_tdata[31:16]),
        .in_dist          (s_tdata[63:32]),
        .in_type          (s_tdata[65:64]),
        .in_last          (s_tlast),
        .in_ready         (s_tready),
        .radius_threshold (radius_threshold),
        .max_conns        (max_conns),
        .drain_idle       (drain_idle),
        .flush            (flush),
        .flush_list       (flush_list)
    );

    // Drain the closed list one item per cycle, while m_tready does not stall, into the output register
    nwrs_drain u_drain (
        .clk          (clk),
        .rst_n        (rst_n),
        .flush        (flush),
        .flush_list   (flush_list),
        .drain_idle   (drain_idle),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_source   (out_source),
        .out_dest     (out_dest),
        .out_type     (out_type),
        .out_distance (out_distance),
        .empty_flag   (m_tuser),
        .last_result  (m_tlast)
    );

    assign m_tdata = {6'd0, out_distance, out_type, out_dest, out_source};

endmodule

`default_nettype wire
